### src/ukt_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the unique key table.
// No dependencies; imported by the controller, datapath and top level.
package ukt_pkg;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_LIST   = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_LISTED    = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	// Where the next result takes its entry fields from.
	typedef enum logic [1:0] {
		OSRC_ZERO = 2'b01,
		OSRC_RD   = 2'b10,
		OSRC_MIN  = 2'b11
	} osrc_t;

	typedef struct packed {
		logic [63:0]        tag;
		logic signed [31:0] bal;
		logic signed [31:0] key;
	} entry_t;

	typedef struct packed {
		logic    latch;
		logic    idx_clr;
		logic    idx_inc;
		logic    idx_ld_min;
		logic    rd_en;
		logic    rd_next;
		logic    wr_ins;
		logic    wr_shift;
		logic    cnt_dec;
		logic    min_upd;
		logic    out_load;
		osrc_t   out_src;
		status_t out_code;
		logic    out_last;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic full;
		logic idx_last;
		logic key_match;
		logic out_free;
	} sts_t;

endpackage

### src/ukt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the unique key table: decodes a request and steps the datapath.
// Depends on ukt_pkg for the command, status and code types.
module ukt_ctrl
	import ukt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  func_t      req_func,
	output logic       req_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_RESP    = 12'b000000000010,
		S_INS_RD  = 12'b000000000100,
		S_INS_CHK = 12'b000000001000,
		S_INS_WR  = 12'b000000010000,
		S_LST_RD  = 12'b000000100000,
		S_LST_OUT = 12'b000001000000,
		S_RM_RD   = 12'b000010000000,
		S_RM_CHK  = 12'b000100000000,
		S_RM_OUT  = 12'b001000000000,
		S_SH_RD   = 12'b010000000000,
		S_SH_WR   = 12'b100000000000
	} state_t;

	state_t  state_q, state_d;
	status_t code_q, code_d;

	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_INSERTED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		code_d       = code_q;
		cmd          = '0;
		cmd.out_src  = OSRC_ZERO;
		cmd.out_code = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch   = 1'b1;
					cmd.idx_clr = 1'b1;
					unique case (req_func)
						FUNC_INSERT: begin
							if (sts.full) begin
								code_d  = ST_FULL;
								state_d = S_RESP;
							end else if (sts.count_zero) begin
								state_d = S_INS_WR;
							end else begin
								state_d = S_INS_RD;
							end
						end
						FUNC_LIST, FUNC_REMOVE: begin
							if (sts.count_zero) begin
								code_d  = ST_EMPTY;
								state_d = S_RESP;
							end else begin
								state_d = (req_func == FUNC_LIST) ? S_LST_RD : S_RM_RD;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_INS_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_INS_CHK;
			end
			S_INS_CHK: begin
				if (sts.key_match) begin
					code_d  = ST_DUPLICATE;
					state_d = S_RESP;
				end else if (sts.idx_last) begin
					state_d = S_INS_WR;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_INS_RD;
				end
			end
			S_INS_WR: begin
				cmd.wr_ins = 1'b1;
				code_d     = ST_INSERTED;
				state_d    = S_RESP;
			end
			S_LST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LST_OUT;
			end
			S_LST_OUT: begin
				cmd.out_src  = OSRC_RD;
				cmd.out_code = ST_LISTED;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = sts.idx_last;
					if (sts.idx_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_LST_RD;
					end
				end
			end
			S_RM_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_RM_CHK;
			end
			S_RM_CHK: begin
				cmd.min_upd = 1'b1;
				if (sts.idx_last) begin
					state_d = S_RM_OUT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RM_RD;
				end
			end
			S_RM_OUT: begin
				cmd.out_src  = OSRC_MIN;
				cmd.out_code = ST_REMOVED;
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_last   = 1'b1;
					cmd.idx_ld_min = 1'b1;
					state_d        = S_SH_RD;
				end
			end
			S_SH_RD: begin
				// close the gap one entry at a time, then drop the count
				if (sts.idx_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
					state_d     = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_SH_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### src/ukt_dp.sv
`timescale 1ns / 1ps
// Datapath of the unique key table: entry memory, count, scan index, minimum
// tracker and result register. Depends on ukt_pkg; driven by ukt_ctrl commands.
module ukt_dp
	import ukt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	output sts_t          sts,
	input  entry_t        req_entry,
	output logic          res_valid,
	input  logic          res_ready,
	output status_t       res_status,
	output entry_t        res_entry,
	output logic          res_last
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	entry_t          mem [CAPACITY];
	entry_t          rd_q;
	entry_t          req_q;
	entry_t          min_q;
	logic [IW-1:0]   min_idx_q;
	logic [IW-1:0]   idx_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   rd_addr;
	logic [IW-1:0]   wr_addr;
	entry_t          wr_data;
	logic            wr_en;
	logic            take_min;

	assign rd_addr = cmd.rd_next ? idx_q + 1'b1 : idx_q;
	assign wr_addr = cmd.wr_ins ? count_q[IW-1:0] : idx_q;
	assign wr_data = cmd.wr_ins ? req_q : rd_q;
	assign wr_en   = cmd.wr_ins | cmd.wr_shift;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_entry;
		end
		if (cmd.min_upd && take_min) begin
			min_q     <= rd_q;
			min_idx_q <= idx_q;
		end
	end

	// first entry seeds the minimum; later ones replace it only when strictly lower
	assign take_min = (idx_q == '0) || ($signed(rd_q.bal) < $signed(min_q.bal));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.wr_ins) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			priority if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_ld_min) begin
				idx_q <= min_idx_q;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_status <= cmd.out_code;
			res_last   <= cmd.out_last;
			unique case (cmd.out_src)
				OSRC_RD:  res_entry <= rd_q;
				OSRC_MIN: res_entry <= min_q;
				default:  res_entry <= '0;
			endcase
		end
	end

	assign sts.count_zero = (count_q == '0);
	assign sts.full       = (count_q == CW'(CAPACITY));
	assign sts.idx_last   = (CW'(idx_q) == count_q - 1'b1);
	assign sts.key_match  = (rd_q.key == req_q.key);
	assign sts.out_free   = !res_valid || res_ready;

endmodule

### src/unique_key_table_with_remove_min.sv
`timescale 1ns / 1ps
// Unique key table with remove-min: keeps up to CAPACITY entries of key,
// signed balance (hundredths) and owner tag in a compact, ordered table.
// Requests arrive on the s_ group: s_tuser is the operation (insert, list,
// remove-min), s_tdata carries key, balance and tag for an insert.
// Results leave on the m_ group: m_tuser is the status, m_tdata the entry
// fields, m_tlast marks the final result of a request.
// One request is worked on at a time; s_tready is high only while idle.
// Every entry access goes through the table memory with a registered read, so
// each visited entry takes a read state and then a check, output or write state:
//   insert      duplicate scan over N entries, then the write
//   list        one result per entry, waiting while the receiver keeps m_tready low
//   remove-min  scan for the minimum, result load, shifts that close the gap
//               at m (the minimum's position), then the count update
// where N is the number of stored entries. An empty table or a full one on
// insert answers without a scan. The result register holds its data while
// m_tready is low and the sequencer waits for it to drain.
// Reset empties the table (count to zero); memory contents are left as is.
// Depends on ukt_pkg, ukt_ctrl and ukt_dp.
module unique_key_table_with_remove_min
	import ukt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // key[31:0], balance[63:32], owner_tag[127:64]
	input  logic [1:0]   s_tuser,   // func[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // entry_key[31:0], entry_balance[63:32], entry_tag[127:64]
	output logic [2:0]   m_tuser,   // status[2:0]
	output logic         m_tlast    // last
);

	cmd_t    cmd;
	sts_t    sts;
	entry_t  req_entry;
	entry_t  res_entry;
	status_t res_status;

	assign req_entry.key = s_tdata[31:0];
	assign req_entry.bal = s_tdata[63:32];
	assign req_entry.tag = s_tdata[127:64];

	ukt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_func  (func_t'(s_tuser)),
		.req_ready (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ukt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_entry  (req_entry),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_status (res_status),
		.res_entry  (res_entry),
		.res_last   (m_tlast)
	);

	assign m_tdata = {res_entry.tag, res_entry.bal, res_entry.key};
	assign m_tuser = res_status;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result loaded over an undelivered result");

	a_no_ins_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_ins |-> !sts.full)
		else $error("insert written into a full table");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.rd_next) |-> !sts.idx_last)
		else $error("shift read past the last entry");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !s_tready)
		else $error("unexpected accept during result load");

endmodule

### tb/ukt_table_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the unique key table: keeps its own copy of the table, works out
// the results of every accepted request and checks each result on the m_ group.
// Depends on ukt_pkg for the operation and status codes.
module ukt_table_checker
	import ukt_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int REPORT_MAX = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,   // key[31:0], balance[63:32], owner_tag[127:64]
	input  logic [1:0]   s_tuser,   // func[1:0]
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,   // entry_key[31:0], entry_balance[63:32], entry_tag[127:64]
	input  logic [2:0]   m_tuser,   // status[2:0]
	input  logic         m_tlast,
	output int           mismatches,
	output int           pending
);

	typedef struct packed {
		status_t     status;
		logic [31:0] key;
		logic [31:0] bal;
		logic [63:0] tag;
		logic        last;
	} table_result_t;

	logic [31:0]   tbl_key [CAPACITY];
	logic [31:0]   tbl_bal [CAPACITY];
	logic [63:0]   tbl_tag [CAPACITY];
	int            tbl_count = 0;
	table_result_t owed_results [$];
	int            errors = 0;
	int            err_r = 0;
	int            pend_r = 0;

	assign mismatches = err_r;
	assign pending    = pend_r;

	function automatic table_result_t mk_result(input status_t st, input logic [31:0] k,
			input logic [31:0] b, input logic [63:0] t, input logic l);
		table_result_t r;
		r.status = st;
		r.key    = k;
		r.bal    = b;
		r.tag    = t;
		r.last   = l;
		return r;
	endfunction

	// Apply one request to the table copy and queue the results it owes.
	task automatic table_step(input func_t op, input logic [31:0] k,
			input logic [31:0] b, input logic [63:0] t);
		int i;
		int m;
		bit dup;
		dup = 1'b0;
		m = 0;
		case (op)
			FUNC_INSERT: begin
				// full takes precedence over a duplicate key
				if (tbl_count >= CAPACITY) begin
					owed_results.push_back(mk_result(ST_FULL, '0, '0, '0, 1'b1));
				end else begin
					for (i = 0; i < tbl_count; i++)
						if (tbl_key[i] == k)
							dup = 1'b1;
					if (dup) begin
						owed_results.push_back(mk_result(ST_DUPLICATE, '0, '0, '0, 1'b1));
					end else begin
						tbl_key[tbl_count] = k;
						tbl_bal[tbl_count] = b;
						tbl_tag[tbl_count] = t;
						tbl_count++;
						owed_results.push_back(mk_result(ST_INSERTED, '0, '0, '0, 1'b1));
					end
				end
			end
			FUNC_LIST, FUNC_REMOVE: begin
				if (tbl_count == 0) begin
					owed_results.push_back(mk_result(ST_EMPTY, '0, '0, '0, 1'b1));
				end else if (op == FUNC_LIST) begin
					for (i = 0; i < tbl_count; i++)
						owed_results.push_back(mk_result(ST_LISTED, tbl_key[i], tbl_bal[i],
							tbl_tag[i], i == tbl_count - 1));
				end else begin
					// strict less-than keeps the lowest position on a tie
					for (i = 1; i < tbl_count; i++)
						if ($signed(tbl_bal[i]) < $signed(tbl_bal[m]))
							m = i;
					owed_results.push_back(mk_result(ST_REMOVED, tbl_key[m], tbl_bal[m],
						tbl_tag[m], 1'b1));
					for (i = m; i < tbl_count - 1; i++) begin
						tbl_key[i] = tbl_key[i + 1];
						tbl_bal[i] = tbl_bal[i + 1];
						tbl_tag[i] = tbl_tag[i + 1];
					end
					tbl_count--;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			tbl_count = 0;
			owed_results.delete();
			pend_r <= 0;
		end else begin
			// check results first: a result seen now never belongs to a request taken now
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("unexpected result: st=%0d key=%h bal=%h tag=%h last=%0b",
							m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[127:64], m_tlast);
				end else begin
					want = owed_results.pop_front();
					if (m_tuser !== want.status || m_tdata[31:0] !== want.key ||
							m_tdata[63:32] !== want.bal || m_tdata[127:64] !== want.tag ||
							m_tlast !== want.last) begin
						errors++;
						if (errors <= REPORT_MAX) begin
							$display("result mismatch: expected st=%0d key=%h bal=%h tag=%h last=%0b",
								want.status, want.key, want.bal, want.tag, want.last);
							$display("                 actual   st=%0d key=%h bal=%h tag=%h last=%0b",
								m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[127:64], m_tlast);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				table_step(func_t'(s_tuser), s_tdata[31:0], s_tdata[63:32], s_tdata[127:64]);
			err_r  <= errors;
			pend_r <= owed_results.size();
		end
	end

endmodule

### tb/unique_key_table_with_remove_min_tb.sv
`timescale 1ns / 1ps
// Top of the unique key table bench: clock, reset, request stimulus and receiver
// backpressure, a stall watchdog and the verdict.
// Depends on ukt_pkg, unique_key_table_with_remove_min and ukt_table_checker.
module unique_key_table_with_remove_min_tb;
	import ukt_pkg::*;

	localparam int CAPACITY     = 16;
	localparam int RANDOM_ITEMS = 105;
	localparam int LONG_HOLD    = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 100;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	int snd_idle_pct = 38;
	int rcv_idle_pct = 86;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatches;
	int pending;

	logic [31:0] key_pool [$];

	always #5 clk = ~clk;

	unique_key_table_with_remove_min #(.CAPACITY(CAPACITY)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	ukt_table_checker #(.CAPACITY(CAPACITY)) table_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Receiver: random backpressure, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= LONG_HOLD;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one request and hold it until the block takes it.
	task automatic send_req(input func_t op, input logic [31:0] k,
			input logic [31:0] b, input logic [63:0] t);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {t, b, k};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random_req(input int insert_pct, output bit counted);
		int          sel;
		func_t       op;
		logic [31:0] k;
		logic [31:0] b;
		logic [63:0] t;
		sel = $urandom_range(99);
		if (sel < insert_pct)
			op = FUNC_INSERT;
		else if (sel < insert_pct + (95 - insert_pct) / 2)
			op = FUNC_REMOVE;
		else if (sel < 95)
			op = FUNC_LIST;
		else
			op = FUNC_NONE;
		// reuse earlier keys now and then to provoke duplicates
		if (key_pool.size() > 0 && $urandom_range(3) == 0)
			k = key_pool[$urandom_range(key_pool.size() - 1)];
		else if ($urandom_range(4) == 0)
			k = $urandom_range(15);
		else
			k = $urandom;
		// narrow balances make ties likely
		if ($urandom_range(2) == 0)
			b = $urandom_range(8) - 4;
		else
			b = $urandom;
		t = {$urandom, $urandom};
		if (op == FUNC_INSERT) begin
			key_pool.push_back(k);
			if (key_pool.size() > 24)
				void'(key_pool.pop_front());
		end
		send_req(op, k, b, t);
		counted = (op != FUNC_NONE);
	endtask

	initial begin
		int i;
		int ph;
		int n;
		int ins_pct;
		bit counted;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, ignored code, field extremes, duplicate, tie, full
		send_req(FUNC_LIST, '0, '0, '0);
		send_req(FUNC_REMOVE, '1, '1, '1);
		send_req(FUNC_NONE, $urandom, $urandom, {$urandom, $urandom});
		send_req(FUNC_INSERT, 32'h8000_0000, 32'h7fff_ffff, '1);
		send_req(FUNC_INSERT, 32'h7fff_ffff, 32'h8000_0000, '0);
		send_req(FUNC_INSERT, 32'h8000_0000, 32'h0000_0000, '1);
		send_req(FUNC_INSERT, 32'h0000_0000, 32'h8000_0000, 64'h0123_4567_89ab_cdef);
		send_req(FUNC_LIST, '0, '0, '0);
		send_req(FUNC_REMOVE, '0, '0, '0);
		for (i = 0; i < CAPACITY - 2; i++)
			send_req(FUNC_INSERT, 32'd100 + i, $urandom, {$urandom, $urandom});
		// full table with a key that is also a duplicate
		send_req(FUNC_INSERT, 32'h0000_0000, 32'd1, 64'd1);
		send_req(FUNC_LIST, '0, '0, '0);

		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					snd_idle_pct = 38;
					rcv_idle_pct = 86;
					ins_pct = 30;
				end
				1: begin
					snd_idle_pct = 86;
					rcv_idle_pct = 38;
					ins_pct = 60;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
					ins_pct = 45;
					// stall the receiver while requests keep coming
					hold_seq <= hold_seq + 1;
				end
			endcase
			n = 0;
			while (n < RANDOM_ITEMS / 3) begin
				send_random_req(ins_pct, counted);
				if (counted)
					n++;
			end
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
src/ukt_pkg.sv
src/ukt_ctrl.sv
src/ukt_dp.sv
src/unique_key_table_with_remove_min.sv
tb/ukt_table_checker.sv
tb/unique_key_table_with_remove_min_tb.sv
